// File: rtl/rfp_pkg.sv
// ============================================================================
// rfp_pkg
// Shared types and constants for the ring FIFO with peek: field widths,
// operation and status codes, controller states and the command bundle.
// ============================================================================
package rfp_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int WORD_WIDTH_DEFAULT = 32;

    localparam int KIND_W   = 2;
    localparam int WORD_W   = 32;
    localparam int OFFSET_W = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    // s_axis_tdata: push_word, peek_offset, padded to whole bytes
    localparam int IN_DATA_W  = ((WORD_W + OFFSET_W + 7) / 8) * 8;
    // m_axis_tdata: read_word, fill_count, free_space, is_empty, padded
    localparam int OUT_DATA_W = ((WORD_W + COUNT_W + COUNT_W + 1 + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_PEEK  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_MISS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic capture;   // latch the accepted operation
        logic exec;      // run the operation against the indices and RAM
        logic load;      // move the finished result into the output register
    } rfp_cmd_t;

endpackage

// File: rtl/rfp_ram.sv
// ============================================================================
// rfp_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module rfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/rfp_ctrl.sv
// ============================================================================
// rfp_ctrl
// Operation sequencer: accept, execute, then hand the result to the output
// register once it is free.
// ============================================================================
module rfp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rfp_pkg::rfp_cmd_t cmd
);
    import rfp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // hold until the output register is empty or draining
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/rfp_datapath.sv
// ============================================================================
// rfp_datapath
// Head/tail indices, slot RAM and the result registers.
// ============================================================================
module rfp_datapath #(
    parameter int DEPTH      = rfp_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = rfp_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rfp_pkg::rfp_cmd_t             cmd,
    input  logic [rfp_pkg::KIND_W-1:0]    kind,
    input  logic [rfp_pkg::WORD_W-1:0]    push_word,
    input  logic [rfp_pkg::OFFSET_W-1:0]  peek_offset,
    output logic [rfp_pkg::STATUS_W-1:0]  status,
    output logic [rfp_pkg::WORD_W-1:0]    read_word,
    output logic [rfp_pkg::COUNT_W-1:0]   fill_count,
    output logic [rfp_pkg::COUNT_W-1:0]   free_space,
    output logic                          is_empty
);
    import rfp_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = (AW > COUNT_W) ? AW : COUNT_W;
    localparam int MAXW = (WORD_WIDTH > WORD_W) ? WORD_WIDTH : WORD_W;

    // captured operation
    kind_t                kind_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [OFFSET_W-1:0]  offset_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;

    // pending result, waiting for the RAM read
    status_t       pend_status_reg, pend_status_next;
    logic          pend_hit_reg, pend_hit_next;
    logic [AW-1:0] pend_fill_reg, pend_fill_next;

    logic [STATUS_W-1:0] status_reg;
    logic [WORD_W-1:0]   read_word_reg;
    logic [COUNT_W-1:0]  fill_count_reg;
    logic [COUNT_W-1:0]  free_space_reg;
    logic                is_empty_reg;

    logic [AW-1:0]         fill_now;
    logic [AW-1:0]         tail_inc;
    logic [AW-1:0]         raddr;
    logic                  ram_we;
    logic                  ram_re;
    logic [MAXW-1:0]       wide_in;
    logic [WORD_WIDTH-1:0] ram_wdata;
    logic [WORD_WIDTH-1:0] ram_rdata;
    logic [MAXW-1:0]       wide_out;
    logic [CW-1:0]         fill_ext;
    logic [CW-1:0]         offset_ext;

    assign wide_in   = MAXW'(word_reg);
    assign ram_wdata = wide_in[WORD_WIDTH-1:0];
    assign wide_out  = MAXW'(ram_rdata);

    assign fill_now   = tail_reg - head_reg;
    assign tail_inc   = tail_reg + AW'(1);
    assign fill_ext   = CW'(fill_now);
    assign offset_ext = CW'(offset_reg);

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        pend_status_next = STATUS_OK;
        pend_hit_next    = 1'b0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        raddr            = head_reg;
        case (kind_reg)
            KIND_PUSH:
            begin
                if (tail_inc == head_reg)
                begin
                    pend_status_next = STATUS_FULL;
                end
                else
                begin
                    ram_we    = cmd.exec;
                    tail_next = tail_inc;
                end
            end
            KIND_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    pend_status_next = STATUS_MISS;
                end
                else
                begin
                    ram_re        = cmd.exec;
                    pend_hit_next = 1'b1;
                    head_next     = head_reg + AW'(1);
                end
            end
            KIND_PEEK:
            begin
                // fill not above offset also covers the empty case
                if (fill_ext <= offset_ext)
                begin
                    pend_status_next = STATUS_MISS;
                end
                else
                begin
                    ram_re        = cmd.exec;
                    pend_hit_next = 1'b1;
                    raddr         = head_reg + AW'(offset_reg);
                end
            end
            KIND_CLEAR:
            begin
                head_next = '0;
                tail_next = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
        pend_fill_next = tail_next - head_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind_t'(kind);
            word_reg   <= push_word;
            offset_reg <= peek_offset;
        end
        if (cmd.exec)
        begin
            pend_status_reg <= pend_status_next;
            pend_hit_reg    <= pend_hit_next;
            pend_fill_reg   <= pend_fill_next;
        end
        if (cmd.load)
        begin
            status_reg     <= pend_status_reg;
            read_word_reg  <= pend_hit_reg ? wide_out[WORD_W-1:0] : '0;
            fill_count_reg <= COUNT_W'(CW'(pend_fill_reg));
            free_space_reg <= COUNT_W'(CW'(~pend_fill_reg));
            is_empty_reg   <= (pend_fill_reg == '0);
        end
    end

    rfp_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign status     = status_reg;
    assign read_word  = read_word_reg;
    assign fill_count = fill_count_reg;
    assign free_space = free_space_reg;
    assign is_empty   = is_empty_reg;

endmodule

// File: rtl/ring_fifo_with_peek.sv
// ============================================================================
// ring_fifo_with_peek
// Ring FIFO of DEPTH slots holding up to DEPTH-1 words, driven by a stream
// of push / pop / peek / clear operations, one result per operation.
// ============================================================================
// Usage:
//   Input channel (s_axis): one transfer per operation. tuser carries the
//   operation kind, tdata the word to push and the peek offset.
//   Output channel (m_axis): one transfer per operation, in order. tuser
//   carries the status (ok, full, miss), tdata the word read plus the fill
//   count, free space and empty flag after the operation.
//   Sequencing: the sequencer steps through accept, execute (index update,
//   RAM write or RAM read issue) and result load, the last step set by the
//   registered read port of the slot RAM. A new operation is accepted only
//   after the previous one has reached the load step and been loaded.
//   The output register lets a new operation be taken while the previous
//   result is still waiting; when the receiver stalls, the finished result
//   holds in the load step until the output register frees.
//   Reset: head and tail return to zero (FIFO empty); no result is pending.
//   Slot contents are not cleared, and only slots already written are read.
// ============================================================================
module ring_fifo_with_peek #(
    parameter int DEPTH      = rfp_pkg::DEPTH_DEFAULT,
    parameter int WORD_WIDTH = rfp_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] push_word, [35:32] peek_offset, rest zero
    input  logic [rfp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [rfp_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] read_word, [35:32] fill_count, [39:36] free_space,
    // [40] is_empty, rest zero
    output logic [rfp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [rfp_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import rfp_pkg::*;

    rfp_cmd_t           cmd;
    logic [WORD_W-1:0]  read_word;
    logic [COUNT_W-1:0] fill_count;
    logic [COUNT_W-1:0] free_space;
    logic               is_empty;

    // sequencer: owns both handshakes
    rfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // indices, slot RAM and result registers
    rfp_datapath #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (s_axis_tuser),
        .push_word   (s_axis_tdata[WORD_W-1:0]),
        .peek_offset (s_axis_tdata[WORD_W +: OFFSET_W]),
        .status      (m_axis_tuser),
        .read_word   (read_word),
        .fill_count  (fill_count),
        .free_space  (free_space),
        .is_empty    (is_empty)
    );

    // pack result fields from the lowest bit up, zero fill to the byte
    assign m_axis_tdata = OUT_DATA_W'({is_empty, free_space, fill_count, read_word});

endmodule

// File: sim/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for ring_fifo_with_peek. A shadow copy of the ring
// (slots, head and tail) predicts each result as operations are accepted;
// results are checked in order, field by field, against that shadow.
// ============================================================================
module testbench;

    import rfp_pkg::*;

    localparam int RING_SLOTS  = DEPTH_DEFAULT;
    localparam int MAX_HELD    = RING_SLOTS - 1;
    localparam int RANDOM_OPS  = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 16;
    localparam int REPORT_MAX  = 10;

    // One predicted result, as the output transfer should carry it
    typedef struct packed {
        status_t                status;
        logic [WORD_W-1:0]      read_word;
        logic [COUNT_W-1:0]     fill_count;
        logic [COUNT_W-1:0]     free_space;
        logic                   is_empty;
    } fifo_result_t;

    // ------------------------------------------------------------------------
    // Shadow ring and queue of predicted results
    // ------------------------------------------------------------------------
    class fifo_shadow;
        logic [WORD_W-1:0]   slots [RING_SLOTS];
        logic [COUNT_W-1:0]  head;
        logic [COUNT_W-1:0]  tail;
        fifo_result_t        pending_results [$];
        int                  mismatches;
        int                  checked;
        int                  kind_hits [4];
        int                  status_hits [3];

        function new();
            head = '0;
            tail = '0;
            mismatches = 0;
            checked = 0;
            foreach (kind_hits[i]) kind_hits[i] = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function logic [COUNT_W-1:0] held();
            return tail - head;
        endfunction

        // Apply one accepted operation to the shadow and queue its result
        function void note_op(kind_t kind, logic [WORD_W-1:0] word,
                              logic [OFFSET_W-1:0] offset);
            fifo_result_t res;
            logic [COUNT_W-1:0] n;
            res = '0;
            res.status = STATUS_OK;
            kind_hits[kind]++;
            case (kind)
                KIND_PUSH:
                begin
                    if (COUNT_W'(tail + 1'b1) == head)
                        res.status = STATUS_FULL;
                    else
                    begin
                        slots[tail] = word;
                        tail = tail + 1'b1;
                    end
                end
                KIND_POP:
                begin
                    if (head == tail)
                        res.status = STATUS_MISS;
                    else
                    begin
                        res.read_word = slots[head];
                        head = head + 1'b1;
                    end
                end
                KIND_PEEK:
                begin
                    // out of range covers the empty ring as well
                    if (offset >= held())
                        res.status = STATUS_MISS;
                    else
                        res.read_word = slots[COUNT_W'(head + offset)];
                end
                default:
                begin
                    head = '0;
                    tail = '0;
                end
            endcase
            n = held();
            res.fill_count = n;
            res.free_space = COUNT_W'(MAX_HELD) - n;
            res.is_empty   = (n == '0);
            status_hits[res.status]++;
            pending_results.push_back(res);
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("[%0t] result %0d: %s", $time, checked, what);
        endfunction

        // Compare one output transfer with the oldest prediction
        function void check_result(logic [STATUS_W-1:0] status,
                                   logic [OUT_DATA_W-1:0] data);
            fifo_result_t want;
            checked++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected transfer, status %0d data %h",
                                 status, data));
                return;
            end
            want = pending_results.pop_front();
            if (status != want.status)
                report($sformatf("status expected %0d, got %0d",
                                 want.status, status));
            if (data[31:0] != want.read_word)
                report($sformatf("read_word expected %h, got %h",
                                 want.read_word, data[31:0]));
            if (data[35:32] != want.fill_count)
                report($sformatf("fill_count expected %0d, got %0d",
                                 want.fill_count, data[35:32]));
            if (data[39:36] != want.free_space)
                report($sformatf("free_space expected %0d, got %0d",
                                 want.free_space, data[39:36]));
            if (data[40] != want.is_empty)
                report($sformatf("is_empty expected %0d, got %0d",
                                 want.is_empty, data[40]));
            if (data[OUT_DATA_W-1:41] != '0)
                report($sformatf("padding expected zero, got %h",
                                 data[OUT_DATA_W-1:41]));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata = '0;
    logic [KIND_W-1:0]        s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0]      m_axis_tuser;

    // idling on both sides is switched off for one long stretch
    bit                       idle_on = 1'b1;
    int                       cycles = 0;
    fifo_shadow               ring_model = new();

    initial
    begin
        forever #4 clk = ~clk;
    end

    ring_fifo_with_peek dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, ring_model.pending());
            $display("ring_fifo_with_peek: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: check each output transfer, stall at random.
    // Values read right after the edge are the ones the edge sampled.
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                ring_model.check_result(m_axis_tuser, m_axis_tdata);
            m_axis_tready <= !(idle_on && $urandom_range(99) < 25) && rst_n;
        end
    end

    // ------------------------------------------------------------------------
    // Operation side. Called at a clock edge; returns at the edge of the
    // transfer. tvalid stays high between back-to-back operations and is
    // dropped only in a gap, so it never gets two updates in one step.
    // ------------------------------------------------------------------------
    task automatic send_op(kind_t kind, logic [WORD_W-1:0] word,
                           logic [OFFSET_W-1:0] offset);
        while (idle_on && $urandom_range(99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(IN_DATA_W - WORD_W - OFFSET_W){1'b0}}, offset, word};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ring_model.note_op(kind, word, offset);
    endtask

    // Directed corners: empty, full, offset limits, clear
    task automatic run_directed();
        logic [WORD_W-1:0] word;
        send_op(KIND_POP, 32'h1234_5678, 4'hF);
        send_op(KIND_PEEK, '0, 4'h0);
        send_op(KIND_CLEAR, 32'hFFFF_FFFF, 4'hF);
        for (int i = 0; i < MAX_HELD; i++)
        begin
            case (i)
                0:       word = 32'h0000_0000;
                1:       word = 32'hFFFF_FFFF;
                2:       word = 32'hAAAA_AAAA;
                3:       word = 32'h5555_5555;
                default: word = $urandom();
            endcase
            send_op(KIND_PUSH, word, OFFSET_W'($urandom_range(15)));
        end
        // ring is full now: the push is refused
        send_op(KIND_PUSH, 32'hDEAD_BEEF, 4'h0);
        send_op(KIND_PEEK, '0, 4'h0);
        send_op(KIND_PEEK, '0, 4'(MAX_HELD - 1));
        send_op(KIND_PEEK, '0, 4'hF);
        send_op(KIND_POP, '0, '0);
        send_op(KIND_CLEAR, '0, '0);
        send_op(KIND_POP, '0, '0);
    endtask

    // Random traffic that swings between filling and draining, so the ring
    // reaches full and empty and the indices wrap many times
    task automatic run_random();
        bit                   filling;
        int                   n;
        int                   r;
        kind_t                kind;
        logic [OFFSET_W-1:0]  offset;
        filling = 1'b1;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            idle_on = !(i >= 250 && i < 400);
            n = ring_model.held();
            if (n == MAX_HELD && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (n == 0)
                filling = 1'b1;
            r = $urandom_range(99);
            if (r < 3)
                kind = KIND_CLEAR;
            else if (r < 30)
                kind = KIND_PEEK;
            else if (r < (filling ? 80 : 45))
                kind = KIND_PUSH;
            else
                kind = KIND_POP;
            // mostly in-range offsets, some anywhere in the field
            if (n > 0 && $urandom_range(3) != 0)
                offset = OFFSET_W'($urandom_range(n - 1));
            else
                offset = OFFSET_W'($urandom_range(15));
            send_op(kind, $urandom(), offset);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        while (ring_model.pending() != 0)
            @(posedge clk);
        // keep running on to catch a stray extra transfer
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("ops: push %0d, pop %0d, peek %0d, clear %0d; results checked %0d",
                 ring_model.kind_hits[KIND_PUSH], ring_model.kind_hits[KIND_POP],
                 ring_model.kind_hits[KIND_PEEK], ring_model.kind_hits[KIND_CLEAR],
                 ring_model.checked);
        $display("status: ok %0d, refused on full %0d, empty or out of range %0d; errors %0d",
                 ring_model.status_hits[STATUS_OK], ring_model.status_hits[STATUS_FULL],
                 ring_model.status_hits[STATUS_MISS], ring_model.mismatches);
        if (ring_model.mismatches == 0 && ring_model.pending() == 0)
            $display("ring_fifo_with_peek: match");
        else
            $display("ring_fifo_with_peek: mismatch");
        $finish;
    end

endmodule
